// ===== rtl/grte_pkg.sv =====
// Shared constants, codes and types of the group reference template expander.
package grte_pkg;

    localparam int MAX_GROUPS = 14;
    localparam int SLOT_BYTES = 32;

    localparam int NSLOTS  = MAX_GROUPS + 2;
    localparam int PH_SLOT = MAX_GROUPS + 1;
    localparam int SLOT_W  = $clog2(NSLOTS);
    localparam int OFF_W   = $clog2(SLOT_BYTES);
    localparam int LEN_W   = $clog2(SLOT_BYTES + 1);
    localparam int GN_W    = $clog2(MAX_GROUPS + 2);
    localparam int ACC_W   = GN_W + 4;
    localparam int ADDR_W  = SLOT_W + OFF_W;
    localparam int MEM_DEPTH = NSLOTS * (2 ** OFF_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [3:0]  SLOT_PH_CODE = 4'hF;
    localparam logic [7:0]  NUL_BYTE     = 8'h00;
    localparam logic [7:0]  CHAR_ZERO    = 8'h30;
    localparam int          DEC_BASE     = 10;
    localparam logic [7:0]  DIGIT_MAX    = CHAR_ZERO + 8'(DEC_BASE - 1);
    localparam logic [15:0] POS_MAX      = 16'hFFFF;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_LEN   = 2'd1,
        REQ_FMT   = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_OK   = 2'd1,
        KIND_FAIL = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MODE_LIT = 2'd0,
        MODE_ESC = 2'd1,
        MODE_DIG = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ESCAPE   = 3'd0,
        CFG_GROUPS   = 3'd1,
        CFG_PH_EN    = 3'd2,
        CFG_OUT_EN   = 3'd3,
        CFG_CAPACITY = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } t_state;

    // Results still owed for the current item: slot copy, then a byte,
    // then a terminating zero, then the job result.
    typedef struct packed {
        logic [LEN_W-1:0] cnt;
        logic             tb;
        logic [7:0]       tb_byte;
        logic             zero;
        logic             fin;
        t_kind            kind;
        logic [15:0]      err_start;
        logic [15:0]      err_end;
    } t_plan;

endpackage

// ===== rtl/group_reference_template_expander.sv =====
// A result enters the output register in the cycle its item is accepted, or after
// the registered memory read when slot text is read; one further result follows
// each cycle while the output is not stalled. Slot writes, length sets and literal
// format bytes do not hold off the next item; a group reference holds off input
// while the single read port fetches its slot bytes. Up to 34 results per item.
// Reset: synchronous, active low; presets config, clears state and slot lengths; slot text kept.
module group_reference_template_expander (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [grte_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [grte_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_req_type,
    input  logic [3:0]                            i_slot,
    input  logic [4:0]                            i_offset,
    input  logic [7:0]                            i_data_byte,
    input  logic [5:0]                            i_slot_length,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [7:0]                            o_out_byte,
    output logic [1:0]                            o_kind,
    output logic [15:0]                           o_err_start,
    output logic [15:0]                           o_err_end,
    output logic                                  o_last
);

    grte_pkg::t_state                  r_state, n_state;
    logic [7:0]                        r_cfg_esc;
    logic [3:0]                        r_cfg_gc;
    logic                              r_cfg_ph;
    logic                              r_cfg_oe;
    logic [15:0]                       r_cfg_cap;

    logic [grte_pkg::LEN_W-1:0]        r_slot_len [grte_pkg::NSLOTS];
    logic [grte_pkg::LEN_W-1:0]        n_slot_len [grte_pkg::NSLOTS];

    grte_pkg::t_mode                   r_mode, n_mode;
    logic [grte_pkg::GN_W-1:0]         r_gn, n_gn;
    logic [15:0]                       r_room, n_room;
    logic [15:0]                       r_pos, n_pos;
    logic [15:0]                       r_esc, n_esc;
    logic [15:0]                       r_fail, n_fail;
    logic                              r_skip, n_skip;
    logic                              r_active, n_active;

    grte_pkg::t_plan                   r_plan, n_plan;
    logic [grte_pkg::SLOT_W-1:0]       r_slot, n_slot;
    logic [grte_pkg::OFF_W-1:0]        r_off, n_off;

    logic                              r_out_valid, n_out_valid;
    logic [7:0]                        r_out_byte, n_out_byte;
    grte_pkg::t_kind                   r_out_kind, n_out_kind;
    logic [15:0]                       r_out_es, n_out_es;
    logic [15:0]                       r_out_ee, n_out_ee;
    logic                              r_out_last, n_out_last;

    logic [7:0]                        mem [grte_pkg::MEM_DEPTH];
    logic [7:0]                        r_mem_q;
    logic                              mem_we;
    logic [grte_pkg::ADDR_W-1:0]       mem_waddr;
    logic [grte_pkg::ADDR_W-1:0]       mem_raddr;

    logic                              out_free;
    logic                              in_acc;
    logic                              in_slot_ok;
    logic [grte_pkg::SLOT_W-1:0]       in_s;
    logic [7:0]                        b;
    logic                              digit;
    logic [3:0]                        dval;
    logic [grte_pkg::GN_W-1:0]         gc;
    logic [grte_pkg::GN_W-1:0]         gc_p1;
    logic [grte_pkg::ACC_W-1:0]        acc;
    logic                              lit_go;
    logic                              miss;
    logic [grte_pkg::SLOT_W-1:0]       tgt;
    logic [grte_pkg::LEN_W-1:0]        len_t;
    grte_pkg::t_plan                   p;
    logic                              hd_go;
    grte_pkg::t_plan                   hd_plan;
    logic                              last_now;

    assign o_cfg_ready = 1'b1;
    assign out_free    = ~r_out_valid | i_out_ready;
    assign o_in_ready  = (r_state == grte_pkg::ST_IDLE) & out_free;
    assign in_acc      = i_in_valid & o_in_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_kind      = r_out_kind;
    assign o_err_start = r_out_es;
    assign o_err_end   = r_out_ee;
    assign o_last      = r_out_last;

    assign in_slot_ok = (i_slot == grte_pkg::SLOT_PH_CODE)
                      || (32'(i_slot) <= grte_pkg::MAX_GROUPS);
    assign in_s = (i_slot == grte_pkg::SLOT_PH_CODE) ? grte_pkg::SLOT_W'(grte_pkg::PH_SLOT)
                                                     : grte_pkg::SLOT_W'(i_slot);

    assign b     = i_data_byte;
    assign digit = (b >= grte_pkg::CHAR_ZERO) && (b <= grte_pkg::DIGIT_MAX);
    assign dval  = 4'(b - grte_pkg::CHAR_ZERO);
    assign gc    = (32'(r_cfg_gc) > grte_pkg::MAX_GROUPS) ? grte_pkg::GN_W'(grte_pkg::MAX_GROUPS)
                                                          : grte_pkg::GN_W'(r_cfg_gc);
    assign gc_p1 = gc + grte_pkg::GN_W'(1);

    assign mem_waddr = {in_s, grte_pkg::OFF_W'(i_offset)};
    assign mem_raddr = {n_slot, n_off};

    always_comb begin
        n_state     = r_state;
        n_slot_len  = r_slot_len;
        n_mode      = r_mode;
        n_gn        = r_gn;
        n_room      = r_room;
        n_pos       = r_pos;
        n_esc       = r_esc;
        n_fail      = r_fail;
        n_skip      = r_skip;
        n_active    = r_active;
        n_plan      = r_plan;
        n_slot      = r_slot;
        n_off       = r_off;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_out_byte  = r_out_byte;
        n_out_kind  = r_out_kind;
        n_out_es    = r_out_es;
        n_out_ee    = r_out_ee;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        p           = '0;
        lit_go      = 1'b0;
        miss        = 1'b0;
        tgt         = '0;
        len_t       = '0;
        acc         = '0;
        hd_go       = 1'b0;
        hd_plan     = r_plan;
        last_now    = 1'b0;

        if (in_acc) begin
            unique case (i_req_type)
                grte_pkg::REQ_WRITE: begin
                    if (in_slot_ok && (32'(i_offset) < grte_pkg::SLOT_BYTES)) begin
                        mem_we = 1'b1;
                    end
                end
                grte_pkg::REQ_LEN: begin
                    if (in_slot_ok) begin
                        n_slot_len[in_s] = (32'(i_slot_length) > grte_pkg::SLOT_BYTES)
                                         ? grte_pkg::LEN_W'(grte_pkg::SLOT_BYTES)
                                         : grte_pkg::LEN_W'(i_slot_length);
                    end
                end
                grte_pkg::REQ_FMT: begin
                    // first format byte of a job loads capacity and clears the parse
                    if (!r_active) begin
                        n_room = r_cfg_cap;
                        n_pos  = '0;
                        n_esc  = '0;
                        n_fail = '0;
                        n_mode = grte_pkg::MODE_LIT;
                        n_gn   = '0;
                        n_skip = 1'b0;
                    end
                    n_active = 1'b1;

                    if (!n_skip) begin
                        unique case (n_mode)
                            grte_pkg::MODE_ESC: begin
                                if (b == grte_pkg::NUL_BYTE) begin
                                    n_fail = n_pos;
                                    n_skip = 1'b1;
                                end else if (b == r_cfg_esc) begin
                                    if (r_cfg_oe) begin
                                        if (n_room == '0) begin
                                            n_esc  = '0;
                                            n_fail = n_pos;
                                            n_skip = 1'b1;
                                        end else begin
                                            p.tb      = 1'b1;
                                            p.tb_byte = b;
                                            n_room    = n_room - 16'd1;
                                        end
                                    end
                                    n_mode = grte_pkg::MODE_LIT;
                                end else if (digit) begin
                                    n_gn   = grte_pkg::GN_W'(dval);
                                    n_mode = grte_pkg::MODE_DIG;
                                end else begin
                                    n_fail = n_pos;
                                    n_skip = 1'b1;
                                end
                            end
                            grte_pkg::MODE_DIG: begin
                                if (digit) begin
                                    acc = grte_pkg::ACC_W'(n_gn) * grte_pkg::ACC_W'(grte_pkg::DEC_BASE)
                                        + grte_pkg::ACC_W'(dval);
                                    // saturate to the missing-group number
                                    n_gn = (acc > grte_pkg::ACC_W'(gc)) ? gc_p1
                                                                        : acc[grte_pkg::GN_W-1:0];
                                end else begin
                                    if (n_gn == '0) begin
                                        tgt = '0;
                                    end else if (n_gn <= gc) begin
                                        tgt = grte_pkg::SLOT_W'(n_gn);
                                    end else if (!r_cfg_ph) begin
                                        miss = 1'b1;
                                    end else begin
                                        tgt = grte_pkg::SLOT_W'(grte_pkg::PH_SLOT);
                                    end
                                    if (miss) begin
                                        n_fail = n_pos;
                                        n_skip = 1'b1;
                                    end else begin
                                        len_t = r_slot_len[tgt];
                                        if (r_cfg_oe) begin
                                            if (n_room < 16'(len_t)) begin
                                                n_esc  = '0;
                                                n_fail = n_pos;
                                                n_skip = 1'b1;
                                            end else begin
                                                p.cnt  = len_t;
                                                n_room = n_room - 16'(len_t);
                                            end
                                        end
                                    end
                                    if (!n_skip) begin
                                        n_gn   = '0;
                                        n_mode = grte_pkg::MODE_LIT;
                                        lit_go = 1'b1;
                                    end
                                end
                            end
                            default: begin
                                lit_go = 1'b1;
                            end
                        endcase
                    end

                    if (lit_go && (b != grte_pkg::NUL_BYTE)) begin
                        if (b == r_cfg_esc) begin
                            n_esc  = n_pos;
                            n_mode = grte_pkg::MODE_ESC;
                        end else if (r_cfg_oe) begin
                            if (n_room == '0) begin
                                n_esc  = '0;
                                n_fail = n_pos;
                                n_skip = 1'b1;
                            end else begin
                                p.tb      = 1'b1;
                                p.tb_byte = b;
                                n_room    = n_room - 16'd1;
                            end
                        end
                    end

                    if (b != grte_pkg::NUL_BYTE) begin
                        if (n_pos != grte_pkg::POS_MAX) begin
                            n_pos = n_pos + 16'd1;
                        end
                    end else begin
                        // terminator: zero byte when output is on and capacity is nonzero, then the job result
                        if (!n_skip && r_cfg_oe) begin
                            if (n_room == '0) begin
                                n_esc  = '0;
                                n_fail = n_pos;
                                n_skip = 1'b1;
                            end else begin
                                p.tb      = 1'b1;
                                p.tb_byte = grte_pkg::NUL_BYTE;
                            end
                        end
                        p.fin = 1'b1;
                        if (n_skip) begin
                            p.zero      = r_cfg_oe && (r_cfg_cap != '0);
                            p.kind      = grte_pkg::KIND_FAIL;
                            p.err_start = n_esc;
                            p.err_end   = n_fail;
                        end else begin
                            p.kind = grte_pkg::KIND_OK;
                        end
                        n_active = 1'b0;
                        n_skip   = 1'b0;
                        n_mode   = grte_pkg::MODE_LIT;
                        n_gn     = '0;
                        n_pos    = '0;
                        n_esc    = '0;
                        n_fail   = '0;
                        n_room   = '0;
                    end

                    n_plan = p;
                    if (p.cnt != '0) begin
                        // first slot byte comes from memory next cycle
                        n_slot  = tgt;
                        n_off   = '0;
                        n_state = grte_pkg::ST_EMIT;
                    end else if (p.tb || p.zero || p.fin) begin
                        hd_go   = 1'b1;
                        hd_plan = p;
                        n_state = grte_pkg::ST_EMIT;
                    end
                end
                default: begin
                end
            endcase
        end

        if ((r_state == grte_pkg::ST_EMIT) && out_free) begin
            hd_go   = 1'b1;
            hd_plan = r_plan;
        end

        if (hd_go) begin
            n_plan      = hd_plan;
            n_out_valid = 1'b1;
            n_out_byte  = grte_pkg::NUL_BYTE;
            n_out_kind  = grte_pkg::KIND_BYTE;
            n_out_es    = '0;
            n_out_ee    = '0;
            priority if (hd_plan.cnt != '0) begin
                n_out_byte = r_mem_q;
                last_now   = (hd_plan.cnt == grte_pkg::LEN_W'(1))
                           && !hd_plan.tb && !hd_plan.zero && !hd_plan.fin;
                n_plan.cnt = hd_plan.cnt - grte_pkg::LEN_W'(1);
                n_off      = r_off + grte_pkg::OFF_W'(1);
            end else if (hd_plan.tb) begin
                n_out_byte = hd_plan.tb_byte;
                last_now   = !hd_plan.zero && !hd_plan.fin;
                n_plan.tb  = 1'b0;
            end else if (hd_plan.zero) begin
                last_now    = !hd_plan.fin;
                n_plan.zero = 1'b0;
            end else begin
                n_out_kind = hd_plan.kind;
                n_out_es   = hd_plan.err_start;
                n_out_ee   = hd_plan.err_end;
                last_now   = 1'b1;
                n_plan.fin = 1'b0;
            end
            n_out_last = last_now;
            if (last_now) begin
                n_state = grte_pkg::ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= grte_pkg::ST_IDLE;
            r_cfg_esc   <= 8'd92;
            r_cfg_gc    <= '0;
            r_cfg_ph    <= 1'b0;
            r_cfg_oe    <= 1'b1;
            r_cfg_cap   <= 16'hFFFF;
            r_slot_len  <= '{default: '0};
            r_mode      <= grte_pkg::MODE_LIT;
            r_gn        <= '0;
            r_room      <= '0;
            r_pos       <= '0;
            r_esc       <= '0;
            r_fail      <= '0;
            r_skip      <= 1'b0;
            r_active    <= 1'b0;
            r_plan      <= '0;
            r_slot      <= '0;
            r_off       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot_len  <= n_slot_len;
            r_mode      <= n_mode;
            r_gn        <= n_gn;
            r_room      <= n_room;
            r_pos       <= n_pos;
            r_esc       <= n_esc;
            r_fail      <= n_fail;
            r_skip      <= n_skip;
            r_active    <= n_active;
            r_plan      <= n_plan;
            r_slot      <= n_slot;
            r_off       <= n_off;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    grte_pkg::CFG_ESCAPE:   r_cfg_esc <= i_cfg_data[7:0];
                    grte_pkg::CFG_GROUPS:   r_cfg_gc  <= i_cfg_data[3:0];
                    grte_pkg::CFG_PH_EN:    r_cfg_ph  <= i_cfg_data[0];
                    grte_pkg::CFG_OUT_EN:   r_cfg_oe  <= i_cfg_data[0];
                    grte_pkg::CFG_CAPACITY: r_cfg_cap <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_kind <= n_out_kind;
        r_out_es   <= n_out_es;
        r_out_ee   <= n_out_ee;
        r_out_last <= n_out_last;
    end

    // slot text: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= i_data_byte;
        end
        r_mem_q <= mem[mem_raddr];
    end

endmodule
